>>> sv/wrg_pkg.sv
`default_nettype none

package wrg_pkg;

    // default geometry and word size
    localparam int DEF_MAX_WIDTH   = 64;
    localparam int DEF_MAX_HEIGHT  = 64;
    localparam int DEF_HEIGHT_BITS = 16;

    // result height width on the port
    localparam int OUT_BITS = 16;

    // configuration port
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 7;
    localparam int DAMP_BITS     = 4;

    localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_DAMP   = 2'd2;

    localparam logic [CFG_DATA_BITS-1:0] RST_WIDTH  = 7'd64;
    localparam logic [CFG_DATA_BITS-1:0] RST_HEIGHT = 7'd64;
    localparam logic [DAMP_BITS-1:0]     RST_DAMP   = 4'd6;

    // operation codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_STONE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [5:0]  pos_x;
        logic [5:0]  pos_y;
        logic [6:0]  stone_size;
        logic [14:0] stone_weight;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] height_value;
        logic                       read_valid;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TICK,
        ST_SETUP,
        ST_SQUARE,
        ST_STONE,
        ST_READ,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

>>> sv/water_ripple_grid.sv
`default_nettype none

// channel   | beat carries                         | direction | handshake
// ----------+--------------------------------------+-----------+-------------------------
// in        | operation, pos, stone size / weight  | into      | i_in_valid / o_in_stall
// out       | height_value, read_valid             | out of    | o_out_valid / i_out_stall
// cfg       | width, height, damping shift         | into      | i_cfg_we, no wait
//
// one item at a time; every input beat yields exactly one output beat
// tick: each interior point reads up/down, then left/right neighbours, because the
//   current plane memory has two read ports and each point needs four neighbours
// stone: sweeps the square round the centre, one point per cycle, writing those
//   inside the disc; with no disc nothing is written
// after reset a clearing pass zeroes every entry of both plane memories, one entry a
//   cycle, input stalled
// a finished result sits in the output register, so a stalled output only holds
//   up the item after the one waiting

module water_ripple_grid #(
    parameter int MAX_WIDTH   = wrg_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = wrg_pkg::DEF_MAX_HEIGHT,
    parameter int HEIGHT_BITS = wrg_pkg::DEF_HEIGHT_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  wrg_pkg::t_in_item                    i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output wrg_pkg::t_out_item                   o_out_data,
    input  logic                                 i_cfg_we,
    input  logic [wrg_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [wrg_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);
    import wrg_pkg::*;

    // address is {y, x}, x field padded to a power of two
    localparam int XB    = $clog2(MAX_WIDTH);
    localparam int YB    = $clog2(MAX_HEIGHT);
    localparam int AW    = XB + YB;
    localparam int DEPTH = 2 ** AW;
    localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    // coordinate arithmetic width, signed, covers 7-bit register values too
    localparam int CB    = $clog2((MAXD > 128) ? MAXD : 128) + 2;
    localparam int H     = HEIGHT_BITS;
    localparam int SB    = ((H > 16) ? H : 16) + 1;
    localparam int EB    = (H > OUT_BITS) ? H : OUT_BITS;

    // ---------------------------------------------------------------- state
    t_state                     r_state, n_state;
    logic                       r_plane_sel;
    logic [AW-1:0]              r_clr;

    logic [CFG_DATA_BITS-1:0]   r_cfg_w, r_cfg_h;
    logic [DAMP_BITS-1:0]       r_cfg_d;

    // latched item
    logic [1:0]                 r_op;
    logic [CB-1:0]              r_px, r_py, r_size;
    logic [14:0]                r_weight;
    logic                       r_in_range;

    // tick walk and update pipeline
    logic [CB-1:0]              r_wx, r_wy;
    logic                       r_phase, r_issue;
    logic                       r_p1, r_p2, r_p3;
    logic [AW-1:0]              r_p1_addr, r_p2_addr, r_p3_addr;
    logic signed [H:0]          r_ud;
    logic signed [H-1:0]        r_pv;
    logic signed [H+1:0]        r_v1;

    // stone sweep
    logic signed [CB-1:0]       r_rad, r_dx, r_dy;
    logic signed [2*CB-1:0]     r_rsq;
    logic [H-1:0]               r_stone_val;

    // output register
    logic                       r_out_vld;
    t_out_item                  r_out;

    // plane memories, two read ports each, registered read data
    logic [H-1:0]               r_plane0 [DEPTH];
    logic [H-1:0]               r_plane1 [DEPTH];
    logic [H-1:0]               r_rd0a, r_rd0b, r_rd1a, r_rd1b;

    // ---------------------------------------------------------------- wires
    logic                       w_in_acc, w_out_load;
    logic [CB-1:0]              w_wused, w_hused;
    logic [DAMP_BITS-1:0]       w_d;
    logic                       w_in_range;

    logic [AW-1:0]              w_cur_ra, w_cur_rb, w_prev_ra, w_waddr;
    logic [H-1:0]               w_wdata;
    logic                       w_cur_we, w_prev_we, w_clr_we, w_we0, w_we1;
    logic [AW-1:0]              w_ra0a, w_ra1a;
    logic signed [H-1:0]        w_cur_da, w_cur_db, w_prev_d;

    logic signed [H+1:0]        w_sum4, w_half;
    logic signed [H+2:0]        w_v1x, w_damped;
    logic [H-1:0]               w_upd;

    logic signed [CB-1:0]       w_ca, w_cb, w_cc, w_cd, w_ce, w_rad;
    logic                       w_stone_go, w_stone_last, w_inside;
    logic signed [2*CB-1:0]     w_dx_sq, w_dy_sq, w_dsq;
    logic signed [SB-1:0]       w_negw, w_stone_lo;

    logic signed [EB-1:0]       w_rd_ext;
    t_out_item                  w_result;

    function automatic logic [AW-1:0] addr(input logic [CB-1:0] yv, input logic [CB-1:0] xv);
        return {yv[YB-1:0], xv[XB-1:0]};
    endfunction

    function automatic logic [H-1:0] sat_h(input logic signed [H+2:0] v);
        logic signed [H+2:0] hi;
        logic signed [H+2:0] lo;
        hi = {4'b0000, {(H-1){1'b1}}};
        lo = {4'b1111, {(H-1){1'b0}}};
        if (v > hi) begin
            return hi[H-1:0];
        end else if (v < lo) begin
            return lo[H-1:0];
        end
        return v[H-1:0];
    endfunction

    // ------------------------------------------------------- handshake side
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_out_load  = (r_state == ST_FINISH) && (!r_out_vld || !i_out_stall);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // ------------------------------------------------- registers in use
    always_comb begin
        if (r_cfg_w < 7'd3) begin
            w_wused = CB'(3);
        end else if (CB'(r_cfg_w) > CB'(MAX_WIDTH)) begin
            w_wused = CB'(MAX_WIDTH);
        end else begin
            w_wused = CB'(r_cfg_w);
        end
        if (r_cfg_h < 7'd3) begin
            w_hused = CB'(3);
        end else if (CB'(r_cfg_h) > CB'(MAX_HEIGHT)) begin
            w_hused = CB'(MAX_HEIGHT);
        end else begin
            w_hused = CB'(r_cfg_h);
        end
    end

    // zero damping behaves as a shift of one
    assign w_d = (r_cfg_d == '0) ? DAMP_BITS'(1) : r_cfg_d;

    assign w_in_range = (CB'(i_in_data.pos_x) < w_wused) && (CB'(i_in_data.pos_y) < w_hused);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= RST_WIDTH;
            r_cfg_h <= RST_HEIGHT;
            r_cfg_d <= RST_DAMP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_WIDTH:  r_cfg_w <= i_cfg_data;
                REG_HEIGHT: r_cfg_h <= i_cfg_data;
                REG_DAMP:   r_cfg_d <= i_cfg_data[DAMP_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------ state machine
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (&r_clr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_in_acc) begin
                    unique case (i_in_data.operation)
                        OP_TICK:  n_state = ST_TICK;
                        OP_STONE: n_state = ST_SETUP;
                        OP_READ:  n_state = ST_READ;
                        default:  n_state = ST_FINISH;
                    endcase
                end
            end
            ST_TICK: begin
                // walk finished and pipeline drained
                if (!r_issue && !r_p1 && !r_p2 && !r_p3) begin
                    n_state = ST_FINISH;
                end
            end
            ST_SETUP: begin
                n_state = w_stone_go ? ST_SQUARE : ST_FINISH;
            end
            ST_SQUARE: n_state = ST_STONE;
            ST_STONE: begin
                if (w_stone_last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_READ: n_state = ST_FINISH;
            ST_FINISH: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // memory port control per state
    always_comb begin
        w_cur_ra  = addr(r_py, r_px);
        w_cur_rb  = addr(r_py, r_px);
        w_prev_ra = addr(r_wy, r_wx);
        w_cur_we  = 1'b0;
        w_prev_we = 1'b0;
        w_clr_we  = 1'b0;
        w_waddr   = r_clr;
        w_wdata   = '0;
        unique case (r_state)
            ST_CLEAR: w_clr_we = 1'b1;
            ST_TICK: begin
                if (r_issue && !r_phase) begin
                    // up and down neighbours, previous value from the other plane
                    w_cur_ra = addr(r_wy - CB'(1), r_wx);
                    w_cur_rb = addr(r_wy + CB'(1), r_wx);
                end else if (r_issue) begin
                    // left and right neighbours
                    w_cur_ra = addr(r_wy, r_wx - CB'(1));
                    w_cur_rb = addr(r_wy, r_wx + CB'(1));
                end
                if (r_p3) begin
                    w_prev_we = 1'b1;
                    w_waddr   = r_p3_addr;
                    w_wdata   = w_upd;
                end
            end
            ST_STONE: begin
                if (w_inside) begin
                    w_cur_we = 1'b1;
                    w_waddr  = addr(r_py + r_dy, r_px + r_dx);
                    w_wdata  = r_stone_val;
                end
            end
            default: ;
        endcase
    end

    // logical current / previous ports onto the two physical planes
    assign w_we0  = w_clr_we || (w_cur_we && !r_plane_sel) || (w_prev_we && r_plane_sel);
    assign w_we1  = w_clr_we || (w_cur_we && r_plane_sel) || (w_prev_we && !r_plane_sel);
    assign w_ra0a = r_plane_sel ? w_prev_ra : w_cur_ra;
    assign w_ra1a = r_plane_sel ? w_cur_ra : w_prev_ra;

    assign w_cur_da = r_plane_sel ? r_rd1a : r_rd0a;
    assign w_cur_db = r_plane_sel ? r_rd1b : r_rd0b;
    assign w_prev_d = r_plane_sel ? r_rd0a : r_rd1a;

    always_ff @(posedge i_clk) begin
        if (w_we0) begin
            r_plane0[w_waddr] <= w_wdata;
        end
        r_rd0a <= r_plane0[w_ra0a];
        r_rd0b <= r_plane0[w_cur_rb];
    end

    always_ff @(posedge i_clk) begin
        if (w_we1) begin
            r_plane1[w_waddr] <= w_wdata;
        end
        r_rd1a <= r_plane1[w_ra1a];
        r_rd1b <= r_plane1[w_cur_rb];
    end

    // ------------------------------------------------------ tick datapath
    // stage two: half the neighbour sum minus the previous height
    assign w_sum4 = (H+2)'(r_ud) + (H+2)'(w_cur_da) + (H+2)'(w_cur_db);
    assign w_half = w_sum4 >>> 1;
    // stage three: damping and saturation
    assign w_v1x    = (H+3)'(r_v1);
    assign w_damped = w_v1x - (w_v1x >>> w_d);
    assign w_upd    = sat_h(w_damped);

    always_ff @(posedge i_clk) begin
        if (r_p1) begin
            r_ud <= (H+1)'(w_cur_da) + (H+1)'(w_cur_db);
            r_pv <= w_prev_d;
        end
        if (r_p2) begin
            r_v1 <= w_half - (H+2)'(r_pv);
        end
        r_p1_addr <= w_prev_ra;
        r_p2_addr <= r_p1_addr;
        r_p3_addr <= r_p2_addr;
    end

    // ----------------------------------------------------- stone datapath
    // radius limited by the distance to each grid edge and by the decremented stone size
    assign w_ca = signed'(r_px);
    assign w_cb = signed'(w_wused - CB'(1) - r_px);
    assign w_cc = signed'(r_py);
    assign w_cd = signed'(w_hused - CB'(1) - r_py);
    assign w_ce = signed'(r_size - CB'(1));

    always_comb begin
        w_rad = w_ca;
        if (w_cb < w_rad) begin
            w_rad = w_cb;
        end
        if (w_cc < w_rad) begin
            w_rad = w_cc;
        end
        if (w_cd < w_rad) begin
            w_rad = w_cd;
        end
        if (w_ce < w_rad) begin
            w_rad = w_ce;
        end
    end

    assign w_stone_go = r_in_range && (w_rad > signed'(CB'(0)));

    // minus the weight, clamped to the most negative height
    assign w_negw     = signed'(SB'(0) - SB'(r_weight));
    assign w_stone_lo = {{(SB-H+1){1'b1}}, {(H-1){1'b0}}};

    assign w_dx_sq      = (2*CB)'(r_dx) * (2*CB)'(r_dx);
    assign w_dy_sq      = (2*CB)'(r_dy) * (2*CB)'(r_dy);
    assign w_dsq        = w_dx_sq + w_dy_sq;
    assign w_inside     = (w_dsq < r_rsq);
    assign w_stone_last = (r_dx == signed'(r_rad - CB'(1))) &&
                          (r_dy == signed'(r_rad - CB'(1)));

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_SETUP: begin
                r_rad       <= w_rad;
                r_stone_val <= (w_negw < w_stone_lo) ? w_stone_lo[H-1:0] : w_negw[H-1:0];
            end
            ST_SQUARE: begin
                r_rsq <= (2*CB)'(r_rad) * (2*CB)'(r_rad);
                r_dx  <= signed'(CB'(1) - r_rad);
                r_dy  <= signed'(CB'(1) - r_rad);
            end
            ST_STONE: begin
                if (r_dx == signed'(r_rad - CB'(1))) begin
                    r_dx <= signed'(CB'(1) - r_rad);
                    r_dy <= r_dy + signed'(CB'(1));
                end else begin
                    r_dx <= r_dx + signed'(CB'(1));
                end
            end
            default: ;
        endcase
    end

    // --------------------------------------------------------- item latch
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op       <= i_in_data.operation;
            r_px       <= CB'(i_in_data.pos_x);
            r_py       <= CB'(i_in_data.pos_y);
            r_size     <= CB'(i_in_data.stone_size);
            r_weight   <= i_in_data.stone_weight;
            r_in_range <= w_in_range;
        end
    end

    // ------------------------------------------------------ control regs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_plane_sel <= 1'b0;
            r_clr       <= '0;
            r_issue     <= 1'b0;
            r_phase     <= 1'b0;
            r_wx        <= CB'(1);
            r_wy        <= CB'(1);
            r_p1        <= 1'b0;
            r_p2        <= 1'b0;
            r_p3        <= 1'b0;
        end else begin
            r_state <= n_state;
            r_p1    <= (r_state == ST_TICK) && r_issue && !r_phase;
            r_p2    <= r_p1;
            r_p3    <= r_p2;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (r_state == ST_IDLE && w_in_acc && i_in_data.operation == OP_TICK) begin
                r_issue <= 1'b1;
                r_phase <= 1'b0;
                r_wx    <= CB'(1);
                r_wy    <= CB'(1);
            end else if (r_state == ST_TICK && r_issue) begin
                r_phase <= !r_phase;
                if (r_phase) begin
                    // raster order over the interior points
                    if (r_wx == w_wused - CB'(2)) begin
                        r_wx <= CB'(1);
                        if (r_wy == w_hused - CB'(2)) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_wy <= r_wy + CB'(1);
                        end
                    end else begin
                        r_wx <= r_wx + CB'(1);
                    end
                end
            end
            // planes swap once the last update is written
            if (r_state == ST_TICK && n_state == ST_FINISH) begin
                r_plane_sel <= !r_plane_sel;
            end
        end
    end

    // ------------------------------------------------------ result beat
    // read data stays on port a while the result waits for the output register
    assign w_rd_ext = EB'(w_cur_da);

    always_comb begin
        w_result.height_value = '0;
        w_result.read_valid   = 1'b0;
        if (r_op == OP_READ && r_in_range) begin
            w_result.height_value = w_rd_ext[OUT_BITS-1:0];
            w_result.read_valid   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= w_result;
        end
    end

endmodule

`default_nettype wire

>>> sv/wrg_checker.sv
`default_nettype none

module wrg_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 o_in_stall,
    input  wrg_pkg::t_in_item                    i_in_data,
    input  logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    input  wrg_pkg::t_out_item                   o_out_data
);

    logic w_in_acc;

    assign w_in_acc = i_in_valid && !o_in_stall;

    // clearing pass holds the input off straight after reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input not stalled after reset");

    // one item in flight: an accepted beat closes the input
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_in_stall)
        else $error("second item taken while one is in work");

    // a result only appears out of work on an item
    a_result_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result beat with no item in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result beat changed");

    // a stalled input beat waits unchanged
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_data))
        else $error("stalled input beat changed");

endmodule

bind water_ripple_grid wrg_checker u_wrg_checker (.*);

`default_nettype wire
